@@ rtl/core/roman_numeral_decoder_defines.svh @@
// ----------------------------------------------------------------------------
// Roman numeral decoder assertion macros
// Shared concurrent assertion forms for the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ROMAN_NUMERAL_DECODER_DEFINES_SVH
`define ROMAN_NUMERAL_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define RND_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("roman numeral decoder: same-cycle check failed");
`define RND_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("roman numeral decoder: next-cycle check failed");
`else
`define RND_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RND_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/core/rnd_pkg.sv @@
// ----------------------------------------------------------------------------
// Roman numeral decoder package
// Widths, character codes, symbol values, the redundant-pair check and the saturating accumulate step.
// ----------------------------------------------------------------------------
package rnd_pkg;

  localparam int TOTAL_WIDTH = 24;
  localparam int SYM_W       = 11;

  typedef logic signed [TOTAL_WIDTH-1:0] total_t;
  typedef logic [SYM_W-1:0]              sym_t;

  typedef struct packed {
    total_t sum;
    logic   ovf;
  } acc_t;

  localparam logic [7:0] CHAR_I = 8'h49;
  localparam logic [7:0] CHAR_V = 8'h56;
  localparam logic [7:0] CHAR_X = 8'h58;
  localparam logic [7:0] CHAR_L = 8'h4C;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_D = 8'h44;
  localparam logic [7:0] CHAR_M = 8'h4D;

  localparam total_t TOTAL_MAX   = {1'b0, {(TOTAL_WIDTH-1){1'b1}}};
  localparam total_t TOTAL_MIN   = {1'b1, {(TOTAL_WIDTH-1){1'b0}}};
  localparam total_t TOTAL_ONE   = total_t'(1);
  localparam total_t TOTAL_LIMIT = total_t'(3000);

  function automatic sym_t symbol_value(input logic [7:0] c);
    sym_t v;
    unique case (c)
      CHAR_I:  v = sym_t'(1);
      CHAR_V:  v = sym_t'(5);
      CHAR_X:  v = sym_t'(10);
      CHAR_L:  v = sym_t'(50);
      CHAR_C:  v = sym_t'(100);
      CHAR_D:  v = sym_t'(500);
      CHAR_M:  v = sym_t'(1000);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic redundant_pair(input sym_t h, input sym_t n);
    logic [SYM_W:0] r;
    r = (h < n) ? ({1'b0, n} - {1'b0, h}) : ({1'b0, h} + {1'b0, n});
    return (n != '0) &&
           (r == 12'd5   || r == 12'd10  || r == 12'd50 ||
            r == 12'd100 || r == 12'd500 || r == 12'd1000);
  endfunction

  function automatic acc_t sat_add(input total_t a, input logic signed [SYM_W:0] d);
    logic signed [TOTAL_WIDTH:0] w;
    acc_t res;
    w = (TOTAL_WIDTH+1)'(a) + (TOTAL_WIDTH+1)'(d);
    res.ovf = (w[TOTAL_WIDTH] != w[TOTAL_WIDTH-1]);
    if (res.ovf) begin
      res.sum = w[TOTAL_WIDTH] ? TOTAL_MIN : TOTAL_MAX;
    end else begin
      res.sum = w[TOTAL_WIDTH-1:0];
    end
    return res;
  endfunction

endpackage

@@ rtl/core/rnd_if.sv @@
// ----------------------------------------------------------------------------
// Roman numeral decoder channels
// Valid/ready channels for character words and result words.
// ----------------------------------------------------------------------------
interface rnd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface rnd_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] value;
  logic        error;

  modport source (output valid, output value, output error, input ready);
  modport sink   (input valid, input value, input error, output ready);
endinterface

@@ rtl/core/roman_numeral_decoder.sv @@
// ----------------------------------------------------------------------------
// Roman numeral decoder
// Decodes a Roman numeral sent one character word at a time.
// ----------------------------------------------------------------------------
//  Channel   Direction  Word
//  in_chan   sink       char_code[7:0], last_char
//  out_chan  source     value[11:0], error
//
//  One character word is accepted every cycle while no final character is held back by a stalled result.
//  A final character passes through the input register and then the output register before its result word is valid.
//  Reset is synchronous and clears all numeral state.
//  A stalled result holds back only a following final character; other
//  characters keep flowing through the input register.
// ----------------------------------------------------------------------------
`include "roman_numeral_decoder_defines.svh"

module roman_numeral_decoder (
  input  logic       clk,
  input  logic       rst_n,
  rnd_in_if.sink     in_chan,
  rnd_out_if.source  out_chan
);

  logic                s1_valid_r;
  logic [7:0]          s1_char_r;
  logic                s1_last_r;
  logic                s1_fire;

  rnd_pkg::sym_t       held_value_r, held_value_nxt;
  logic [7:0]          held_char_r, held_char_nxt;
  logic                have_held_r, have_held_nxt;
  logic [1:0]          run_length_r, run_length_nxt;
  logic                error_seen_r, error_seen_nxt;
  rnd_pkg::total_t     total_r, total_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [11:0]         out_value_r, out_value_nxt;
  logic                out_error_r, out_error_nxt;

  rnd_pkg::sym_t       sym;
  logic signed [rnd_pkg::SYM_W:0] held_delta;
  rnd_pkg::acc_t       acc1, acc2;
  logic                err_step;

  assign s1_fire       = s1_valid_r && (!s1_last_r || !out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_fire;

  assign out_chan.valid = out_valid_r;
  assign out_chan.value = out_value_r;
  assign out_chan.error = out_error_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_char_r <= in_chan.char_code;
      s1_last_r <= in_chan.last_char;
    end
  end

  always_comb begin
    sym        = rnd_pkg::symbol_value(s1_char_r);
    held_delta = (held_value_r < sym) ? -$signed({1'b0, held_value_r})
                                      : $signed({1'b0, held_value_r});
    acc1       = have_held_r ? rnd_pkg::sat_add(total_r, held_delta)
                             : rnd_pkg::acc_t'{sum: total_r, ovf: 1'b0};
    acc2       = rnd_pkg::sat_add(acc1.sum, $signed({1'b0, sym}));

    err_step       = error_seen_r || (sym == '0) || acc1.ovf;
    run_length_nxt = 2'd0;
    if (have_held_r) begin
      if (rnd_pkg::redundant_pair(held_value_r, sym)) begin
        err_step = 1'b1;
      end
      if (s1_char_r == held_char_r) begin
        if (run_length_r >= 2'd2) begin
          err_step = 1'b1;
        end
        run_length_nxt = (run_length_r == 2'd3) ? run_length_r : run_length_r + 2'd1;
      end
    end

    held_value_nxt = held_value_r;
    held_char_nxt  = held_char_r;
    have_held_nxt  = have_held_r;
    error_seen_nxt = error_seen_r;
    total_nxt      = total_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_value_nxt  = out_value_r;
    out_error_nxt  = out_error_r;

    if (s1_fire) begin
      if (s1_last_r) begin
        held_value_nxt = '0;
        held_char_nxt  = '0;
        have_held_nxt  = 1'b0;
        run_length_nxt = 2'd0;
        error_seen_nxt = 1'b0;
        total_nxt      = '0;
        out_valid_nxt  = 1'b1;
        out_error_nxt  = err_step || acc2.ovf || (acc2.sum < rnd_pkg::TOTAL_ONE) ||
                         (acc2.sum > rnd_pkg::TOTAL_LIMIT);
        out_value_nxt  = out_error_nxt ? 12'd0 : acc2.sum[11:0];
      end else begin
        held_value_nxt = sym;
        held_char_nxt  = s1_char_r;
        have_held_nxt  = 1'b1;
        error_seen_nxt = err_step;
        total_nxt      = acc1.sum;
      end
    end else begin
      run_length_nxt = run_length_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_value_r <= '0;
      held_char_r  <= '0;
      have_held_r  <= 1'b0;
      run_length_r <= 2'd0;
      error_seen_r <= 1'b0;
      total_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      held_value_r <= held_value_nxt;
      held_char_r  <= held_char_nxt;
      have_held_r  <= have_held_nxt;
      run_length_r <= run_length_nxt;
      error_seen_r <= error_seen_nxt;
      total_r      <= total_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_error_r <= out_error_nxt;
  end

  `RND_ASSERT_IMP(a_error_zero, clk, rst_n, out_valid_r && out_error_r, out_value_r == 12'd0)
  `RND_ASSERT_IMP(a_value_range, clk, rst_n, out_valid_r && !out_error_r,
                  out_value_r >= 12'd1 && out_value_r <= 12'd3000)
  `RND_ASSERT_NEXT(a_final_clears, clk, rst_n, s1_fire && s1_last_r, out_valid_r && !have_held_r && !error_seen_r)
  `RND_ASSERT_IMP(a_run_needs_held, clk, rst_n, run_length_r != 2'd0, have_held_r)
  `RND_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !out_valid_r, in_chan.ready)

endmodule
